// ===== rtl/erf_pkg.sv =====
// erf_pkg: shared constants, register map and sequencer states for the echo range filter.
// No dependencies; imported by echo_range_filter.
`default_nettype none

package erf_pkg;

    // ring depth default (entries of history)
    localparam int ERF_DEPTH = 8;

    // field widths
    localparam int ECHO_W     = 16;   // echo width, us
    localparam int MS_W       = 16;   // millisecond counters and periods
    localparam int DIST_W     = 17;   // accepted distance, never above max_distance_q8
    localparam int OUT_DIST_W = 18;   // reported distance
    localparam int CONF_W     = 9;
    localparam int RAW_DIST_W = 19;   // (65535*4496)>>10 needs 19 bits
    localparam int QUO_W      = 17;   // shared divider quotient: mean < 2^17

    // us -> 1/256 cm: (us*4496)>>10
    localparam int          US_K_W   = 13;
    localparam logic [12:0] US_TO_Q8 = 13'd4496;
    localparam int          US_SHIFT = 10;

    localparam logic [17:0] NONE_Q8 = 18'd255744;   // 999 cm

    // confidence limits, variance in 1/65536 cm^2 scaled by n^2
    localparam int          VAR_LO_SHIFT = 16;          // 1 cm^2
    localparam int          CONST_K_W    = 21;
    localparam logic [20:0] VAR_HI_K     = 21'd1638400; // 25 cm^2
    localparam logic [20:0] CONF_TOP_K   = 21'd1966080; // 30 cm^2
    localparam int          CONF_DIV_W   = 13;
    localparam logic [12:0] CONF_DIV_K   = 13'd7680;    // 30 cm^2 / 256
    localparam logic [8:0]  CONF_FULL    = 9'd256;
    localparam logic [8:0]  CONF_LOW     = 9'd51;
    localparam logic [8:0]  CONF_NONE    = 9'd0;

    // register reset values
    localparam logic [15:0] TRIG_PERIOD_RST = 16'd60;
    localparam logic [15:0] TIMEOUT_RST     = 16'd2000;
    localparam logic [16:0] MIN_DIST_RST    = 17'd512;
    localparam logic [16:0] MAX_DIST_RST    = 17'd102400;

    // register map
    localparam int          APB_AW     = 4;
    localparam logic [3:0]  ADDR_TRIG  = 4'h0;
    localparam logic [3:0]  ADDR_TOUT  = 4'h4;
    localparam logic [3:0]  ADDR_MIN   = 4'h8;
    localparam logic [3:0]  ADDR_MAX   = 4'hC;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_SUM,
        ST_MUL,
        ST_NUM,
        ST_MEAN,
        ST_CLASS,
        ST_CONF,
        ST_TOUT,
        ST_OUT
    } erf_state_t;

endpackage

`default_nettype wire

// ===== rtl/erf_hist_mem.sv =====
// erf_hist_mem: history ring storage, one write and one registered read port.
// Depends on nothing; widths come from the instantiating module.
`default_nettype none

module erf_hist_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 17
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] ram [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/erf_div.sv =====
// erf_div: restoring divider, one quotient bit per cycle, shared by mean and confidence.
// Caller guarantees quotient < 2^QW. Depends on nothing.
`default_nettype none

module erf_div #(
    parameter int NW = 46,
    parameter int BW = 21,
    parameter int QW = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [BW-1:0] divisor,
    output logic               busy,
    output logic      [QW-1:0] quotient
);

    localparam int XW = (NW > BW + QW - 1) ? NW : BW + QW - 1;
    localparam int SW = $clog2(QW);

    logic [XW-1:0] rem_reg;
    logic [XW-1:0] dsr_reg;
    logic [QW-1:0] q_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          fits;

    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && (step_reg == '0)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= XW'(dividend);
            dsr_reg  <= XW'(divisor) << (QW - 1);
            q_reg    <= '0;
            step_reg <= SW'(QW - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsr_reg;
            end
            q_reg    <= {q_reg[QW-2:0], fits};
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - SW'(1);
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/echo_range_filter.sv =====
// echo_range_filter: ultrasonic echo ranging with a moving-average ring and confidence.
// Depends on erf_pkg, erf_hist_mem (history ring) and erf_div (shared divider).
//
//  channel   | ports                       | one request carries
//  ----------+-----------------------------+---------------------------------------------
//  input     | s_tvalid s_tready s_tdata   | tick (tuser 0) or echo width in us (tuser 1)
//            | s_tuser                     |
//  result    | m_tvalid m_tready m_tdata   | trigger, distance, confidence, health, valid
//  config    | psel penable pwrite paddr   | trigger period, timeout, min/max distance
//            | pwdata prdata pready        |
//
// A tick or a rejected echo passes through ST_EVAL, ST_CHECK, ST_TOUT and ST_OUT to the
// result register. An accepted echo walks the ring once through the single memory read
// port (ST_SUM), runs the 17-step divider for the mean (ST_MUL, ST_NUM, ST_MEAN), sorts
// the variance (ST_CLASS) and, when it lies between 1 and 25 cm^2, runs the divider again
// for the confidence (ST_CONF) before ST_TOUT and ST_OUT.
// One request is worked on at a time; the next is taken once the result sits in the
// output register, even while that register is still stalled by m_tready. A result
// waits in its last state while the previous one is still stalled.
// Reset (aresetn, synchronous, active low) restores the register defaults and empties
// the ring through its fill count; the memory itself is never cleared.
`default_nettype none

module echo_range_filter
    import erf_pkg::*;
#(
    parameter int DEPTH = ERF_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] echo_duration_us
    input  wire logic              s_tuser,   // [0] kind
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [31:0]       m_tdata,   // [0] trigger_pulse, [18:1] distance_q8,
                                              // [27:19] confidence_q8, [28] healthy,
                                              // [29] data_valid, [31:30] zero
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    // derived widths
    localparam int IW    = $clog2(DEPTH);          // ring index
    localparam int CW    = $clog2(DEPTH + 1);      // fill count, 0..DEPTH
    localparam int S1W   = DIST_W + IW;            // sum of entries
    localparam int S2W   = 2 * DIST_W + IW;        // sum of squares
    localparam int NUMW  = 2 * DIST_W + 2 * IW;    // n*S2 and S1^2
    localparam int DENW  = 2 * CW;                 // n^2
    localparam int CMPW  = (NUMW > DENW + CONST_K_W) ? NUMW : DENW + CONST_K_W;
    localparam int BW    = DENW + CONF_DIV_W;      // divisor of the confidence division
    localparam int PRODW = ECHO_W + US_K_W;

    // sequencer
    erf_state_t state_reg;
    erf_state_t state_next;

    // configuration registers
    logic [MS_W-1:0]   trig_period_reg;
    logic [MS_W-1:0]   timeout_reg;
    logic [DIST_W-1:0] min_dist_reg;
    logic [DIST_W-1:0] max_dist_reg;
    logic              cfg_we;

    // request being worked on
    logic                  kind_reg;
    logic [ECHO_W-1:0]     us_reg;
    logic [RAW_DIST_W-1:0] dist_reg;

    // block state
    logic [IW-1:0]         wr_idx_reg;
    logic [CW-1:0]         count_reg;
    logic [OUT_DIST_W-1:0] filt_reg;
    logic [CONF_W-1:0]     conf_reg;
    logic                  healthy_reg;
    logic                  valid_reg;
    logic                  trig_reg;
    logic [MS_W-1:0]       ms_trig_reg;
    logic [MS_W-1:0]       ms_valid_reg;
    logic [MS_W-1:0]       ms_trig_next;
    logic [MS_W-1:0]       ms_valid_next;

    // ring walk and statistics
    logic [CW-1:0]       rd_cnt_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic [DIST_W-1:0]   ent_reg;
    logic [2*DIST_W-1:0] sq_reg;
    logic [S1W-1:0]      s1_reg;
    logic [S2W-1:0]      s2_reg;
    logic [NUMW-1:0]     nsq_reg;
    logic [NUMW-1:0]     s1sq_reg;
    logic [DENW-1:0]     den_reg;
    logic [CMPW-1:0]     num_reg;
    logic [CMPW-1:0]     den_hi_reg;
    logic [CMPW-1:0]     den_top_reg;
    logic [BW-1:0]       den_div_reg;
    logic [CMPW-1:0]     den_lo;

    // memory and divider ports
    logic              mem_we;
    logic              mem_re;
    logic [DIST_W-1:0] mem_rdata;
    logic              div_start;
    logic [CMPW-1:0]   div_a;
    logic [BW-1:0]     div_b;
    logic              div_busy;
    logic [QUO_W-1:0]  div_q;

    // decisions
    logic echo_ok;
    logic rd_more;
    logic sum_done;
    logic var_low;
    logic var_high;
    logic out_load;

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_period_reg <= TRIG_PERIOD_RST;
            timeout_reg     <= TIMEOUT_RST;
            min_dist_reg    <= MIN_DIST_RST;
            max_dist_reg    <= MAX_DIST_RST;
        end else if (cfg_we) begin
            unique case (paddr)
                ADDR_TRIG: trig_period_reg <= pwdata[MS_W-1:0];
                ADDR_TOUT: timeout_reg     <= pwdata[MS_W-1:0];
                ADDR_MIN:  min_dist_reg    <= pwdata[DIST_W-1:0];
                ADDR_MAX:  max_dist_reg    <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_TRIG: prdata = 32'(trig_period_reg);
            ADDR_TOUT: prdata = 32'(timeout_reg);
            ADDR_MIN:  prdata = 32'(min_dist_reg);
            ADDR_MAX:  prdata = 32'(max_dist_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // combinational decisions
    // ------------------------------------------------------------------
    // tick: both ms counters advance, saturating
    assign ms_valid_next = (!kind_reg && (ms_valid_reg != '1)) ? ms_valid_reg + MS_W'(1)
                                                               : ms_valid_reg;
    assign ms_trig_next  = (!kind_reg && (ms_trig_reg != '1)) ? ms_trig_reg + MS_W'(1)
                                                              : ms_trig_reg;

    // zero width means no echo; min above max rejects all
    assign echo_ok = kind_reg && (us_reg != '0)
                     && (dist_reg >= RAW_DIST_W'(min_dist_reg))
                     && (dist_reg <= RAW_DIST_W'(max_dist_reg));

    assign rd_more  = (rd_cnt_reg < count_reg);
    assign sum_done = !rd_more && !v1_reg && !v2_reg;

    assign den_lo   = CMPW'(den_reg) << VAR_LO_SHIFT;
    assign var_low  = (num_reg < den_lo);
    assign var_high = (num_reg > den_hi_reg);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_CHECK;
            ST_CHECK: state_next = echo_ok ? ST_SUM : ST_TOUT;
            ST_SUM:   if (sum_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_NUM;
            ST_NUM:   state_next = ST_MEAN;
            ST_MEAN:  if (!div_busy) state_next = ST_CLASS;
            ST_CLASS: state_next = (var_low || var_high) ? ST_TOUT : ST_CONF;
            ST_CONF:  if (!div_busy) state_next = ST_TOUT;
            ST_TOUT:  state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_CHECK: mem_we    = echo_ok;
            ST_SUM:   mem_re    = rd_more;
            ST_MUL:   div_start = 1'b1;
            ST_CLASS: div_start = !(var_low || var_high);
            ST_OUT:   out_load  = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // divider operands: mean first, confidence second
    assign div_a = (state_reg == ST_MUL) ? CMPW'(s1_reg) : den_top_reg - num_reg;
    assign div_b = (state_reg == ST_MUL) ? BW'(count_reg) : den_div_reg;

    // ------------------------------------------------------------------
    // block state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg   <= '0;
            count_reg    <= '0;
            filt_reg     <= NONE_Q8;
            conf_reg     <= CONF_NONE;
            healthy_reg  <= 1'b1;
            valid_reg    <= 1'b0;
            trig_reg     <= 1'b0;
            ms_trig_reg  <= '0;
            ms_valid_reg <= '0;
            rd_cnt_reg   <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            v1_reg <= mem_re;
            v2_reg <= v1_reg;
            if (mem_re) begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            unique case (state_reg)
                ST_EVAL: begin
                    ms_valid_reg <= ms_valid_next;
                    if (ms_trig_next >= trig_period_reg) begin
                        trig_reg    <= 1'b1;
                        ms_trig_reg <= '0;
                    end else begin
                        trig_reg    <= 1'b0;
                        ms_trig_reg <= ms_trig_next;
                    end
                end
                ST_CHECK: begin
                    rd_cnt_reg <= '0;
                    if (echo_ok) begin
                        wr_idx_reg   <= (wr_idx_reg == IW'(DEPTH - 1)) ? '0
                                                                       : wr_idx_reg + IW'(1);
                        if (count_reg != CW'(DEPTH)) begin
                            count_reg <= count_reg + CW'(1);
                        end
                        ms_valid_reg <= '0;
                        healthy_reg  <= 1'b1;
                        valid_reg    <= 1'b1;
                    end
                end
                ST_MEAN: begin
                    if (!div_busy) begin
                        filt_reg <= OUT_DIST_W'(div_q);
                    end
                end
                ST_CLASS: begin
                    if (var_low) begin
                        conf_reg <= CONF_FULL;
                    end else if (var_high) begin
                        conf_reg <= CONF_LOW;
                    end
                end
                ST_CONF: begin
                    if (!div_busy) begin
                        conf_reg <= {1'b0, div_q[7:0]};
                    end
                end
                ST_TOUT: begin
                    if (ms_valid_reg > timeout_reg) begin
                        healthy_reg <= 1'b0;
                        valid_reg   <= 1'b0;
                        filt_reg    <= NONE_Q8;
                        conf_reg    <= CONF_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath, no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            us_reg   <= s_tdata[ECHO_W-1:0];
        end
        if (state_reg == ST_EVAL) begin
            dist_reg <= RAW_DIST_W'((PRODW'(us_reg) * PRODW'(US_TO_Q8)) >> US_SHIFT);
        end
        if (state_reg == ST_CHECK) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (v2_reg) begin
            s1_reg <= s1_reg + S1W'(ent_reg);
            s2_reg <= s2_reg + S2W'(sq_reg);
        end
        if (v1_reg) begin
            ent_reg <= mem_rdata;
            sq_reg  <= (2*DIST_W)'(mem_rdata) * (2*DIST_W)'(mem_rdata);
        end
        if (state_reg == ST_MUL) begin
            nsq_reg  <= NUMW'(count_reg) * NUMW'(s2_reg);
            s1sq_reg <= NUMW'(s1_reg) * NUMW'(s1_reg);
            den_reg  <= DENW'(count_reg) * DENW'(count_reg);
        end
        if (state_reg == ST_NUM) begin
            num_reg     <= CMPW'(nsq_reg - s1sq_reg);
            den_hi_reg  <= CMPW'(den_reg) * CMPW'(VAR_HI_K);
            den_top_reg <= CMPW'(den_reg) * CMPW'(CONF_TOP_K);
            den_div_reg <= BW'(den_reg) * BW'(CONF_DIV_K);
        end
    end

    // ------------------------------------------------------------------
    // history ring and divider
    // ------------------------------------------------------------------
    erf_hist_mem #(
        .DEPTH (DEPTH),
        .AW    (IW),
        .DW    (DIST_W)
    ) u_hist (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_idx_reg),
        .wdata (dist_reg[DIST_W-1:0]),
        .re    (mem_re),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    erf_div #(
        .NW (CMPW),
        .BW (BW),
        .QW (QUO_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, valid_reg, healthy_reg, conf_reg, filt_reg, trig_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
